// ===== hdl/scatter_gather_builder_assert.svh =====
// ----------------------------------------------------------------------------
// Scatter-gather builder assertion macros
// Shorthand for concurrent checks clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SCATTER_GATHER_BUILDER_ASSERT_SVH
`define SCATTER_GATHER_BUILDER_ASSERT_SVH

// same-cycle implication
`define SGB_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sgb: same-cycle check failed");

// next-cycle implication
`define SGB_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sgb: next-cycle check failed");

`endif

// ===== hdl/sgb_pkg.sv =====
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared types and constants of the scatter-gather list builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgb_pkg;

	localparam int unsigned DEFAULT_PAGE_BYTES = 4096;
	localparam int unsigned CNT_W              = 21;
	localparam logic [CNT_W-1:0] CNT_MAX       = '1;
	localparam int unsigned FIFO_DEPTH         = 4;
	localparam int unsigned IN_DATA_W          = 128;
	localparam int unsigned OUT_DATA_W         = 144;

	localparam logic ACTION_START = 1'b0;
	localparam logic ACTION_XLATE = 1'b1;

	typedef enum logic [1:0] {
		KIND_REQ      = 2'd0,
		KIND_ELEM     = 2'd1,
		KIND_BAD      = 2'd2,
		KIND_UNMAPPED = 2'd3
	} sgb_kind_t;

	typedef struct packed {
		logic        action;
		logic [31:0] buf_va;
		logic [31:0] byte_count;
		logic [31:0] transfer_direction;
		logic [31:0] page_pa;
	} sgb_item_t;

	typedef struct packed {
		sgb_kind_t        kind;
		logic [31:0]      address;
		logic [31:0]      length;
		logic [CNT_W-1:0] elem_index;
		logic [CNT_W-1:0] capacity;
		logic [31:0]      direction_out;
		logic             last;
	} sgb_result_t;

	// results produced by one processed item, res[0] goes out first
	typedef struct packed {
		logic [1:0]              count;
		sgb_result_t [1:0]       res;
	} sgb_emit_t;

endpackage

// ===== hdl/sgb_job.sv =====
// ----------------------------------------------------------------------------
// sgb_job
// Job state and per-item result generation of the list builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgb_job
	import sgb_pkg::*;
#(
	parameter int unsigned PAGE_BYTES = DEFAULT_PAGE_BYTES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      go,
	input  sgb_item_t item,
	output sgb_emit_t emit
);

	// PAGE_BYTES must be a power of two
	localparam int unsigned PAGE_W = $clog2(PAGE_BYTES);

	logic             busy_q,      busy_nxt;
	logic [31:0]      cur_virt_q,  cur_virt_nxt;
	logic [31:0]      remain_q,    remain_nxt;
	logic [31:0]      open_phys_q, open_phys_nxt;
	logic [31:0]      open_len_q,  open_len_nxt;
	logic [CNT_W-1:0] elem_total_q, elem_total_nxt;
	logic [CNT_W-1:0] span_q,      span_nxt;
	logic [31:0]      dir_q,       dir_nxt;

	logic [33:0]      span_sum;
	logic [33:0]      span_full;
	logic [CNT_W-1:0] span_sat;
	logic [PAGE_W:0]  chunk;
	logic [31:0]      take;
	logic             contig;
	logic             slot;

	// page span of a new buffer, saturated
	assign span_sum  = 34'(item.buf_va[PAGE_W-1:0]) + 34'(item.byte_count)
	                 + 34'(PAGE_BYTES - 1);
	assign span_full = span_sum >> PAGE_W;
	assign span_sat  = (span_full > 34'(CNT_MAX)) ? CNT_MAX : span_full[CNT_W-1:0];

	// bytes left in the current page, clipped to the buffer end
	assign chunk = (PAGE_W+1)'(PAGE_BYTES) - {1'b0, cur_virt_q[PAGE_W-1:0]};
	assign take  = (32'(chunk) > remain_q) ? remain_q : 32'(chunk);

	// 33-bit sum so the end of the open element never wraps
	assign contig = (elem_total_q != '0)
	             && (({1'b0, open_phys_q} + {1'b0, open_len_q}) == {1'b0, item.page_pa});

	always_comb begin
		busy_nxt       = busy_q;
		cur_virt_nxt   = cur_virt_q;
		remain_nxt     = remain_q;
		open_phys_nxt  = open_phys_q;
		open_len_nxt   = open_len_q;
		elem_total_nxt = elem_total_q;
		span_nxt       = span_q;
		dir_nxt        = dir_q;
		slot           = 1'b0;
		emit           = '0;

		if (go) begin
			if (item.action == ACTION_START) begin
				dir_nxt  = item.transfer_direction;
				busy_nxt = 1'b0;
				emit.count = 2'd1;
				if (item.buf_va == '0 || item.byte_count == '0) begin
					emit.res[0].kind = KIND_BAD;
					emit.res[0].last = 1'b1;
				end else begin
					busy_nxt       = 1'b1;
					cur_virt_nxt   = item.buf_va;
					remain_nxt     = item.byte_count;
					open_phys_nxt  = '0;
					open_len_nxt   = '0;
					elem_total_nxt = '0;
					span_nxt       = span_sat;
					emit.res[0].kind    = KIND_REQ;
					emit.res[0].address = item.buf_va;
				end
			end else if (busy_q) begin
				if (item.page_pa == '0) begin
					busy_nxt = 1'b0;
					emit.count = 2'd1;
					emit.res[0].kind    = KIND_UNMAPPED;
					emit.res[0].address = cur_virt_q;
					emit.res[0].last    = 1'b1;
				end else begin
					if (contig) begin
						open_len_nxt = open_len_q + take;
					end else begin
						if (elem_total_q != '0) begin
							// close the open element
							emit.res[0].kind       = KIND_ELEM;
							emit.res[0].address    = open_phys_q;
							emit.res[0].length     = open_len_q;
							emit.res[0].elem_index = elem_total_q - CNT_W'(1);
							slot = 1'b1;
						end
						open_phys_nxt = item.page_pa;
						open_len_nxt  = take;
						if (elem_total_q != CNT_MAX) begin
							elem_total_nxt = elem_total_q + CNT_W'(1);
						end
					end
					cur_virt_nxt = cur_virt_q + take;
					remain_nxt   = remain_q - take;
					if (remain_nxt == '0) begin
						busy_nxt = 1'b0;
						emit.res[slot].kind       = KIND_ELEM;
						emit.res[slot].address    = open_phys_nxt;
						emit.res[slot].length     = open_len_nxt;
						emit.res[slot].elem_index = elem_total_nxt;
						emit.res[slot].capacity   = span_q;
						emit.res[slot].last       = 1'b1;
					end else begin
						emit.res[slot].kind    = KIND_REQ;
						emit.res[slot].address = cur_virt_nxt;
					end
					emit.count = slot ? 2'd2 : 2'd1;
				end
			end
		end

		emit.res[0].direction_out = dir_nxt;
		emit.res[1].direction_out = dir_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			cur_virt_q   <= '0;
			remain_q     <= '0;
			open_phys_q  <= '0;
			open_len_q   <= '0;
			elem_total_q <= '0;
			span_q       <= '0;
			dir_q        <= '0;
		end else begin
			busy_q       <= busy_nxt;
			cur_virt_q   <= cur_virt_nxt;
			remain_q     <= remain_nxt;
			open_phys_q  <= open_phys_nxt;
			open_len_q   <= open_len_nxt;
			elem_total_q <= elem_total_nxt;
			span_q       <= span_nxt;
			dir_q        <= dir_nxt;
		end
	end

endmodule

// ===== hdl/scatter_gather_builder.sv =====
// ----------------------------------------------------------------------------
// scatter_gather_builder
// Builds a merged scatter-gather element list from page translations.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries commands: tuser = 0 starts a job from buf_va,
//   byte_count and transfer_direction; tuser = 1 returns the physical address
//   page_pa for the last translate request (zero = unmapped page).
//   Master stream carries results: translate requests, list elements and the
//   two error kinds, tuser giving the kind and tlast closing a job.
//   Flow: an accepted beat sits in the input register until the result
//   FIFO has room for two beats; its results are then shown from the FIFO.
//   Throughput: one command per cycle while each yields one result and the
//   receiver keeps tready high; a command that closes one element and emits
//   another yields two beats and the output port drains one beat per cycle,
//   so the result FIFO sets the pace for such commands.
//   Stall: the 4-entry result FIFO keeps taking work while it has room for
//   two beats; when the receiver holds tready low the input register fills
//   and s_axis_tready drops. Nothing is lost or repeated.
//   Reset: arst_n clears the job (idle), the input valid flag and the FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scatter_gather_builder
	import sgb_pkg::*;
#(
	parameter int unsigned PAGE_BYTES = DEFAULT_PAGE_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// buf_va[31:0], byte_count[63:32], transfer_direction[95:64],
	// page_pa[127:96]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// action[0]
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// address[31:0], length[63:32], elem_index[84:64], capacity[105:85],
	// direction_out[137:106], zero fill[143:138]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// kind[1:0]
	output logic [1:0]            m_axis_tuser,
	output logic                  m_axis_tlast
);

	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned FCNT_W = $clog2(FIFO_DEPTH + 1);

	// input register
	sgb_item_t item_s1;
	logic      valid_s1;
	logic      take_s1;
	logic      s_beat;

	// result FIFO
	sgb_result_t              fifo_q [FIFO_DEPTH];
	logic        [PTR_W-1:0]  wr_ptr_q;
	logic        [PTR_W-1:0]  rd_ptr_q;
	logic        [FCNT_W-1:0] cnt_q;
	logic        [FCNT_W-1:0] cnt_nxt;
	logic                     pop;
	logic                     err_beat;
	sgb_result_t              head;

	sgb_emit_t emit;

	assign s_beat = s_axis_tvalid && s_axis_tready;
	// item moves on only when two FIFO slots are free
	assign take_s1 = valid_s1 && (cnt_q <= FCNT_W'(FIFO_DEPTH - 2));
	assign s_axis_tready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_beat) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_beat) begin
			item_s1.action             <= s_axis_tuser;
			item_s1.buf_va             <= s_axis_tdata[31:0];
			item_s1.byte_count         <= s_axis_tdata[63:32];
			item_s1.transfer_direction <= s_axis_tdata[95:64];
			item_s1.page_pa            <= s_axis_tdata[127:96];
		end
	end

	sgb_job #(
		.PAGE_BYTES(PAGE_BYTES)
	) u_job (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (take_s1),
		.item  (item_s1),
		.emit  (emit)
	);

	assign pop = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk) begin
		if (emit.count != 2'd0) begin
			fifo_q[wr_ptr_q] <= emit.res[0];
		end
		if (emit.count == 2'd2) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= emit.res[1];
		end
	end

	assign cnt_nxt = cnt_q + FCNT_W'(emit.count) - FCNT_W'(pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(emit.count);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			cnt_q    <= cnt_nxt;
		end
	end

	assign head          = fifo_q[rd_ptr_q];
	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = {6'b0, head.direction_out, head.capacity, head.elem_index,
	                        head.length, head.address};
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last;

	// error beat shown on the master side
	assign err_beat = m_axis_tvalid
	               && (m_axis_tuser == KIND_BAD || m_axis_tuser == KIND_UNMAPPED);

	`include "scatter_gather_builder_assert.svh"

	`SGB_ASSERT_IMP(a_fifo_bound, 1'b1, cnt_q <= FCNT_W'(FIFO_DEPTH))
	`SGB_ASSERT_NXT(a_fifo_count, 1'b1, cnt_q == $past(cnt_nxt))
	`SGB_ASSERT_IMP(a_err_last, err_beat, m_axis_tlast)
	`SGB_ASSERT_IMP(a_pair_order, emit.count == 2'd2, emit.res[0].kind == KIND_ELEM && !emit.res[0].last)

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for scatter_gather_builder: drives start commands and
// page translations on the command stream, predicts every result beat, and
// matches the result stream beat by beat under random idling and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
	import sgb_pkg::*;
();

	localparam int unsigned PAGE       = DEFAULT_PAGE_BYTES;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned SETTLE      = 8;

	// Predicts the builder's result beats and matches them in order.
	class sg_list_tracker;
		bit              busy;
		logic [31:0]     cur_virt;
		logic [31:0]     remaining;
		logic [31:0]     open_phys;
		logic [31:0]     open_len;
		logic [CNT_W-1:0] elems_opened;
		logic [CNT_W-1:0] span_pages;
		logic [31:0]     dir_code;
		sgb_result_t     queued_list_beats[$];
		int errors, n_cmds, n_checked, n_lists, n_merges, n_bad, n_unmapped, n_ignored;

		function void queue_beat(sgb_kind_t kind, logic [31:0] addr, logic [31:0] len,
				logic [CNT_W-1:0] idx, logic [CNT_W-1:0] cap, logic last);
			sgb_result_t r;
			r.kind          = kind;
			r.address       = addr;
			r.length        = len;
			r.elem_index    = idx;
			r.capacity      = cap;
			r.direction_out = dir_code;
			r.last          = last;
			queued_list_beats.push_back(r);
		endfunction

		function void take_command(sgb_item_t cmd);
			longint unsigned span;
			logic [31:0] chunk;
			logic [31:0] take;
			n_cmds++;
			if (cmd.action == ACTION_START) begin
				dir_code = cmd.transfer_direction;
				busy     = 1'b0;
				if (cmd.buf_va == 0 || cmd.byte_count == 0) begin
					n_bad++;
					queue_beat(KIND_BAD, '0, '0, '0, '0, 1'b1);
					return;
				end
				span = (64'(cmd.buf_va % PAGE) + 64'(cmd.byte_count) + PAGE - 1) / PAGE;
				span_pages = (span > 64'(CNT_MAX)) ? CNT_MAX : span[CNT_W-1:0];
				busy         = 1'b1;
				cur_virt     = cmd.buf_va;
				remaining    = cmd.byte_count;
				open_phys    = '0;
				open_len     = '0;
				elems_opened = '0;
				queue_beat(KIND_REQ, cur_virt, '0, '0, '0, 1'b0);
				return;
			end
			if (!busy) begin
				n_ignored++;
				return;
			end
			if (cmd.page_pa == 0) begin
				busy = 1'b0;
				n_unmapped++;
				queue_beat(KIND_UNMAPPED, cur_virt, '0, '0, '0, 1'b1);
				return;
			end
			chunk = PAGE - (cur_virt % PAGE);
			take  = (chunk > remaining) ? remaining : chunk;
			// contiguity is judged on the 33-bit sum, so a wrapped end never merges
			if (elems_opened != 0
					&& ({1'b0, open_phys} + {1'b0, open_len}) == {1'b0, cmd.page_pa}) begin
				open_len += take;
				n_merges++;
			end else begin
				if (elems_opened != 0)
					queue_beat(KIND_ELEM, open_phys, open_len, elems_opened - 1'b1, '0, 1'b0);
				open_phys = cmd.page_pa;
				open_len  = take;
				if (elems_opened != CNT_MAX)
					elems_opened++;
			end
			cur_virt  += take;
			remaining -= take;
			if (remaining == 0) begin
				busy = 1'b0;
				n_lists++;
				queue_beat(KIND_ELEM, open_phys, open_len, elems_opened, span_pages, 1'b1);
			end else begin
				queue_beat(KIND_REQ, cur_virt, '0, '0, '0, 1'b0);
			end
		endfunction

		function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void match_result(sgb_result_t got);
			sgb_result_t want;
			bit ok;
			if (queued_list_beats.size() == 0) begin
				$display("%0t ns: result beat with nothing pending, kind %0d address %h",
					$time, got.kind, got.address);
				errors++;
				return;
			end
			want = queued_list_beats.pop_front();
			n_checked++;
			ok = field_ok("kind", 32'(want.kind), 32'(got.kind))
				& field_ok("address", want.address, got.address)
				& field_ok("length", want.length, got.length)
				& field_ok("elem_index", 32'(want.elem_index), 32'(got.elem_index))
				& field_ok("capacity", 32'(want.capacity), 32'(got.capacity))
				& field_ok("direction_out", want.direction_out, got.direction_out)
				& field_ok("last", 32'(want.last), 32'(got.last));
			if (!ok)
				errors++;
		endfunction

		function int pending();
			return queued_list_beats.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_valid = 1'b0;
	logic                  s_ready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_valid;
	logic                  m_ready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	sg_list_tracker tracker = new();
	int sent;
	int src_idle_pct;
	int sink_stall_pct;
	int hold_left;
	int quiet_cycles;

	always #2 clk = ~clk;

	scatter_gather_builder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.m_axis_tlast  (m_tlast)
	);

	// command beats are predicted when the handshake completes
	always @(posedge clk) begin
		sgb_item_t cmd;
		if (arst_n && s_valid && s_ready) begin
			cmd.action             = s_tuser;
			cmd.buf_va             = s_tdata[31:0];
			cmd.byte_count         = s_tdata[63:32];
			cmd.transfer_direction = s_tdata[95:64];
			cmd.page_pa            = s_tdata[127:96];
			tracker.take_command(cmd);
		end
	end

	always @(posedge clk) begin
		sgb_result_t got;
		if (arst_n && m_valid && m_ready) begin
			got.kind          = sgb_kind_t'(m_tuser);
			got.address       = m_tdata[31:0];
			got.length        = m_tdata[63:32];
			got.elem_index    = m_tdata[84:64];
			got.capacity      = m_tdata[105:85];
			got.direction_out = m_tdata[137:106];
			got.last          = m_tlast;
			tracker.match_result(got);
		end
	end

	// receiver: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_valid && s_ready) || (m_valid && m_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t ns: no beat moved for %0d cycles", $time, quiet_cycles);
				$display("testbench failed");
				$finish;
			end
		end
	end

	task automatic send(input logic act, input logic [31:0] va, input logic [31:0] bc,
			input logic [31:0] dir, input logic [31:0] pa);
		while ($urandom_range(99) < src_idle_pct) begin
			s_valid <= 1'b0;
			@(posedge clk);
		end
		s_valid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {pa, dir, bc, va};
		@(posedge clk);
		while (!s_ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic wait_drained();
		s_valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.pending() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// one start beat followed by the page answers, cut short at max_answers or an unmapped answer
	task automatic run_job(input logic [31:0] va, input logic [31:0] bc, input int max_answers);
		logic [31:0] cv;
		logic [31:0] rem;
		logic [31:0] chunk;
		logic [31:0] take;
		logic [31:0] pa;
		logic [31:0] next_pa;
		int k;
		send(ACTION_START, va, bc, $urandom, $urandom);
		if (va == 0 || bc == 0)
			return;
		cv      = va;
		rem     = bc;
		next_pa = '0;
		k       = 0;
		while (rem != 0 && k < max_answers) begin
			chunk = PAGE - (cv % PAGE);
			take  = (chunk > rem) ? rem : chunk;
			if ($urandom_range(99) < 3)
				pa = '0;
			else if (k > 0 && next_pa != 0 && $urandom_range(99) < 50)
				pa = next_pa;
			else if ($urandom_range(1))
				pa = {20'($urandom_range(1, 32'hFFFFF)), 12'h000};
			else
				pa = $urandom_range(1, 32'hFFFFFFFF);
			send(ACTION_XLATE, $urandom, $urandom, $urandom, pa);
			if (pa == 0)
				return;
			next_pa = pa + take;
			cv      += take;
			rem     -= take;
			k++;
		end
	endtask

	task automatic random_job();
		logic [31:0] va;
		logic [31:0] bc;
		int max_answers;
		int pick;
		if ($urandom_range(99) < 4) begin
			send(ACTION_XLATE, $urandom, $urandom, $urandom, $urandom);
			return;
		end
		pick = $urandom_range(99);
		if (pick < 4)
			va = '0;
		else if (pick < 14)
			va = 32'hFFFF_F000 | $urandom_range(0, PAGE - 1);
		else if (pick < 24)
			va = {20'($urandom_range(1, 32'hFFFFF)), 12'h000};
		else
			va = $urandom;
		max_answers = 1000;
		pick = $urandom_range(99);
		if (pick < 4) begin
			bc = '0;
		end else if (pick < 14) begin
			bc = $urandom;
			max_answers = $urandom_range(0, 3);
		end else if (pick < 34) begin
			bc = $urandom_range(1, 64);
		end else begin
			bc = $urandom_range(1, 4 * PAGE);
			if ($urandom_range(99) < 5)
				max_answers = $urandom_range(0, 2);
		end
		run_job(va, bc, max_answers);
	endtask

	initial begin
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_left      = 0;
		quiet_cycles   = 0;
		sent           = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stray answer, bad requests, wrapped ends, merges, abandon, unmapped
		send(ACTION_XLATE, '0, '0, '0, 32'h1234_5000);
		send(ACTION_START, '0, 32'd100, 32'h0000_0007, '0);
		send(ACTION_START, 32'h0000_1000, '0, 32'h8000_0000, '0);
		send(ACTION_START, 32'hFFFF_F800, 32'h0000_1000, 32'hFFFF_FFFF, '0);
		send(ACTION_XLATE, '0, '0, '0, 32'hFFFF_FC00);
		send(ACTION_XLATE, '0, '0, '0, 32'h0000_0400);
		send(ACTION_START, 32'h1234_5010, 32'h0000_3000, 32'hA5A5_5A5A, 32'hFFFF_FFFF);
		send(ACTION_XLATE, '0, '0, '0, 32'h8000_0010);
		send(ACTION_XLATE, '0, '0, '0, 32'h8000_1000);
		send(ACTION_XLATE, '0, '0, '0, 32'h8000_2000);
		send(ACTION_XLATE, '0, '0, '0, 32'h9000_0000);
		send(ACTION_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1357_9BDF, '0);
		send(ACTION_XLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(ACTION_XLATE, '0, '0, '0, 32'h0000_0001);
		send(ACTION_START, 32'h0000_0001, 32'h0000_0001, '0, '0);
		send(ACTION_XLATE, '0, '0, '0, 32'hFFFF_FFFF);
		send(ACTION_START, 32'h0000_4000, 32'h0000_2000, 32'h0BAD_F00D, '0);
		send(ACTION_XLATE, '0, '0, '0, 32'h0000_1000);
		send(ACTION_XLATE, '0, '0, '0, '0);
		send(ACTION_XLATE, '0, '0, '0, 32'h0000_2000);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
					// long receiver hold-off while commands keep coming
					hold_left      = 120;
				end
				1: begin
					src_idle_pct   = 45;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct = 45;
				end
				default: begin
					src_idle_pct   = 37;
					sink_stall_pct = 37;
				end
			endcase
			while (sent < 20 + (phase + 1) * 500)
				random_job();
			wait_drained();
		end

		$display("Covered %0d command beats and %0d result beats: %0d lists closed, %0d merges.",
			tracker.n_cmds, tracker.n_checked, tracker.n_lists, tracker.n_merges);
		$display("Error paths: %0d bad requests, %0d unmapped aborts, %0d stray answers.",
			tracker.n_bad, tracker.n_unmapped, tracker.n_ignored);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
